/* src/sprite_pixel_texture_depth_test_assert.svh */
// Assertion macros used by the RTL top file.
`ifndef SPRITE_PIXEL_TEXTURE_DEPTH_TEST_ASSERT_SVH
`define SPRITE_PIXEL_TEXTURE_DEPTH_TEST_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);
`define SPT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error(msg);
`else
`define SPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* src/spt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;
	localparam int TEX_ENTRIES_DEF       = 4096;
	localparam int SCREEN_COORD_BITS_DEF = 12;

	// quotient bits kept by the dividers; a larger quotient is out of texture
	localparam int QBITS   = 7;
	localparam int DIV_LAT = QBITS + 1;
	localparam int IDX_W   = 17;
	localparam int NX_W    = 18;
	localparam int DY_W    = 25;
	localparam int AX_W    = 24;
	localparam int AY_W    = 31;
	localparam int DENX_W  = 16;
	localparam int DENY_W  = 24;

	localparam logic [12:0] SCREEN_W_RST = 13'd640;
	localparam logic [12:0] SCREEN_H_RST = 13'd480;
	localparam logic [6:0]  TEX_W_RST    = 7'd64;
	localparam logic [6:0]  TEX_H_RST    = 7'd64;

	typedef enum logic [1:0] {
		REG_SCREEN_W = 2'd0,
		REG_SCREEN_H = 2'd1,
		REG_TEX_W    = 2'd2,
		REG_TEX_H    = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_DRAW  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        draw;
		logic        ok;
		logic        neg_x;
		logic        neg_y;
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] tex_idx;
		logic [31:0] tex_val;
	} side_t;

	typedef struct packed {
		logic             wr;
		logic             rd;
		logic [IDX_W-1:0] addr;
		logic [31:0]      wdata;
	} mem_req_t;
endpackage
`default_nettype wire

/* src/spt_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface spt_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [11:0] texel_index;
	logic [31:0] texel_value;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic signed [15:0] sprite_center_x;
	logic [15:0] spr_width;
	logic [15:0] spr_height;
	logic signed [31:0] sprite_depth;
	logic [30:0] column_depth;

	modport source (output valid, cmd, texel_index, texel_value, pixel_x, pixel_y,
		sprite_center_x, spr_width, spr_height, sprite_depth, column_depth,
		input ready);
	modport sink (input valid, cmd, texel_index, texel_value, pixel_x, pixel_y,
		sprite_center_x, spr_width, spr_height, sprite_depth, column_depth,
		output ready);
endinterface
`default_nettype wire

/* src/spt_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface spt_rsp_if;
	logic        valid;
	logic        ready;
	logic        pixel_write;
	logic [11:0] out_x;
	logic [11:0] out_y;
	logic [31:0] colour;

	modport source (output valid, pixel_write, out_x, out_y, colour, input ready);
	modport sink (input valid, pixel_write, out_x, out_y, colour, output ready);
endinterface
`default_nettype wire

/* src/spt_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module spt_div import spt_pkg::*; #(
	parameter int NW = AX_W,
	parameter int DW = DENX_W
) (
	input  wire logic               clk,
	input  wire logic [DIV_LAT-1:0] en,
	input  wire logic [NW-1:0]      num,
	input  wire logic [DW-1:0]      den,
	output logic [QBITS-1:0]        quo,
	output logic                    ovf
);
	localparam int CW = ((NW > DW + QBITS) ? NW : DW + QBITS) + 1;

	logic [CW-1:0]    rem_s [DIV_LAT];
	logic [DW-1:0]    den_s [DIV_LAT];
	logic [QBITS-1:0] q_s   [DIV_LAT];
	logic             ovf_s [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0] <= CW'(num);
			den_s[0] <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= CW'(num) >= (CW'(den) << QBITS);
		end
	end

	for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
		logic [CW-1:0] sh_den;
		logic          fit;
		assign sh_den = CW'(den_s[k-1]) << (QBITS - k);
		assign fit    = rem_s[k-1] >= sh_den;
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= fit ? rem_s[k-1] - sh_den : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				q_s[k]   <= q_s[k-1] | (QBITS'(fit) << (QBITS - k));
			end
		end
	end

	assign quo = q_s[DIV_LAT-1];
	assign ovf = ovf_s[DIV_LAT-1];
endmodule
`default_nettype wire

/* src/spt_tex_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// Single-port texture store; one read or write per cycle while en is high, registered read word.
module spt_tex_mem import spt_pkg::*; #(
	parameter int TEX_ENTRIES = TEX_ENTRIES_DEF
) (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire mem_req_t req,
	output logic [31:0]   rdata
);
	localparam int AW = $clog2(TEX_ENTRIES);

	logic [31:0] mem [TEX_ENTRIES];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (req.wr) begin
				mem[req.addr[AW-1:0]] <= req.wdata;
			end
			if (req.rd) begin
				rdata_q <= mem[req.addr[AW-1:0]];
			end
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

/* src/sprite_pixel_texture_depth_test.sv */
// An accepted word passes the offset, scaling, divider, address and memory stages to the result word.
// Throughput: one word per cycle while the output is taken; the two 8-stage dividers
// and the single-port texture memory each take one item per cycle.
// Stalled stages close up, so bubbles are squeezed out under backpressure.
// Reset clears the stage valid bits and loads the configuration defaults;
// the texture store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_pixel_texture_depth_test_assert.svh"
module sprite_pixel_texture_depth_test import spt_pkg::*; #(
	parameter int TEX_ENTRIES       = TEX_ENTRIES_DEF,
	parameter int SCREEN_COORD_BITS = SCREEN_COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [12:0] cfg_wdata,
	spt_req_if.sink          req,
	spt_rsp_if.source        rsp
);
	localparam int NST = DIV_LAT + 4;
	localparam int CB  = (SCREEN_COORD_BITS < 12) ? SCREEN_COORD_BITS : 12;
	localparam logic [11:0] CMASK = 12'((1 << CB) - 1);

	logic [12:0] scr_w_q, scr_h_q;
	logic [6:0]  tex_w_q, tex_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCREEN_W_RST;
			scr_h_q <= SCREEN_H_RST;
			tex_w_q <= TEX_W_RST;
			tex_h_q <= TEX_H_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCREEN_W: scr_w_q <= cfg_wdata;
				REG_SCREEN_H: scr_h_q <= cfg_wdata;
				REG_TEX_W:    tex_w_q <= cfg_wdata[6:0];
				REG_TEX_H:    tex_h_q <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// stage i loads when it is empty or its word moves on
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || rsp.ready;
		for (int i = NST - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= req.valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign req.ready = en[0];

	// stage 1: offsets and coarse tests
	logic            draw_c, ok_c;
	logic [NX_W-1:0] nx_c;
	logic [DY_W-1:0] dy_c;

	always_comb begin
		draw_c = (cmd_t'(req.cmd) == CMD_DRAW);
		ok_c = draw_c && (req.spr_width != '0) && (req.spr_height != '0)
			&& !req.sprite_depth[31] && (req.sprite_depth != '0)
			&& ($signed({1'b0, req.column_depth}) > req.sprite_depth)
			&& (req.pixel_x != '0) && ({1'b0, req.pixel_x} < scr_w_q);
		nx_c = {6'b0, req.pixel_x} + {3'b0, req.spr_width[15:1]}
			- {{2{req.sprite_center_x[15]}}, req.sprite_center_x};
		dy_c = {5'b0, req.pixel_y, 8'b0} + {2'b0, req.spr_height, 7'b0}
			- {5'b0, scr_h_q, 7'b0};
	end

	side_t             side_s1, side_s2, side_s11, side_s12;
	side_t             side_c2, side_c11;
	side_t             side_d [DIV_LAT];
	logic [NX_W-1:0]   nx_s1;
	logic [DY_W-1:0]   dy_s1;
	logic [15:0]       sw_s1, sh_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s1.draw    <= draw_c;
			side_s1.ok      <= ok_c;
			side_s1.neg_x   <= 1'b0;
			side_s1.neg_y   <= 1'b0;
			side_s1.x       <= req.pixel_x;
			side_s1.y       <= req.pixel_y;
			side_s1.tex_idx <= req.texel_index;
			side_s1.tex_val <= req.texel_value;
			nx_s1           <= nx_c;
			dy_s1           <= dy_c;
			sw_s1           <= req.spr_width;
			sh_s1           <= req.spr_height;
		end
	end

	// stage 2: magnitudes scaled by texture size
	logic [NX_W-2:0]   mag_x;
	logic [DY_W-2:0]   mag_y;
	logic [AX_W-1:0]   ax_s2;
	logic [AY_W-1:0]   ay_s2;
	logic [DENX_W-1:0] denx_s2;
	logic [DENY_W-1:0] deny_s2;

	always_comb begin
		mag_x = nx_s1[NX_W-1] ? (NX_W-1)'(-nx_s1) : nx_s1[NX_W-2:0];
		mag_y = dy_s1[DY_W-1] ? (DY_W-1)'(-dy_s1) : dy_s1[DY_W-2:0];
		side_c2       = side_s1;
		side_c2.neg_x = nx_s1[NX_W-1];
		side_c2.neg_y = dy_s1[DY_W-1];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_s2 <= side_c2;
			ax_s2   <= AX_W'(mag_x) * AX_W'(tex_w_q);
			ay_s2   <= AY_W'(mag_y) * AY_W'(tex_h_q);
			denx_s2 <= sw_s1;
			deny_s2 <= {sh_s1, 8'b0};
		end
	end

	// stages 3..10: dividers, sideband travels alongside
	logic [QBITS-1:0] qx, qy;
	logic             ovfx, ovfy;

	spt_div #(.NW(AX_W), .DW(DENX_W)) u_div_x (
		.clk (clk),
		.en  (en[2 +: DIV_LAT]),
		.num (ax_s2),
		.den (denx_s2),
		.quo (qx),
		.ovf (ovfx)
	);

	spt_div #(.NW(AY_W), .DW(DENY_W)) u_div_y (
		.clk (clk),
		.en  (en[2 +: DIV_LAT]),
		.num (ay_s2),
		.den (deny_s2),
		.quo (qy),
		.ovf (ovfy)
	);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			side_d[0] <= side_s2;
		end
		for (int k = 1; k < DIV_LAT; k++) begin
			if (en[2+k]) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// stage 11: texel address and bounds; a negative quotient is valid only as zero
	side_t            side_last;
	logic             tx_ok, ty_ok, in_store;
	logic [13:0]      row_off;
	logic [IDX_W-1:0] idx_c;
	logic [12:0]      ox_full;
	logic [IDX_W-1:0] idx_s11;
	logic [11:0]      ox_s11, ox_s12;

	always_comb begin
		side_last   = side_d[DIV_LAT-1];
		tx_ok       = !ovfx && (!side_last.neg_x || qx == '0) && (qx < tex_w_q);
		ty_ok       = !ovfy && (!side_last.neg_y || qy == '0) && (qy < tex_h_q);
		row_off     = 14'(qy) * 14'(tex_w_q);
		idx_c       = IDX_W'(row_off) + IDX_W'(qx);
		in_store    = idx_c < IDX_W'(TEX_ENTRIES);
		ox_full     = scr_w_q - {1'b0, side_last.x} - 13'd1;
		side_c11    = side_last;
		side_c11.ok = side_last.ok && tx_ok && ty_ok && in_store;
	end

	always_ff @(posedge clk) begin
		if (en[NST-2]) begin
			side_s11 <= side_c11;
			idx_s11  <= idx_c;
			ox_s11   <= ox_full[11:0] & CMASK;
		end
	end

	// texture store access happens in order, as words leave stage 11
	mem_req_t    mreq;
	logic [31:0] texel;

	always_comb begin
		mreq.wr    = vld_q[NST-2] && !side_s11.draw
			&& (IDX_W'(side_s11.tex_idx) < IDX_W'(TEX_ENTRIES));
		mreq.rd    = vld_q[NST-2] && side_s11.draw && side_s11.ok;
		mreq.addr  = side_s11.draw ? idx_s11 : IDX_W'(side_s11.tex_idx);
		mreq.wdata = side_s11.tex_val;
	end

	spt_tex_mem #(.TEX_ENTRIES(TEX_ENTRIES)) u_mem (
		.clk   (clk),
		.en    (en[NST-1]),
		.req   (mreq),
		.rdata (texel)
	);

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			side_s12 <= side_s11;
			ox_s12   <= ox_s11;
		end
	end

	logic hit;
	assign hit = side_s12.draw && side_s12.ok && (texel != '0);

	assign rsp.valid       = vld_q[NST-1];
	assign rsp.pixel_write = hit;
	assign rsp.out_x       = hit ? ox_s12 : '0;
	assign rsp.out_y       = hit ? (side_s12.y & CMASK) : '0;
	assign rsp.colour      = hit ? texel : '0;

	`SPT_ASSERT(a_hit_opaque, clk, arst_n, rsp.valid && rsp.pixel_write |-> rsp.colour != '0, "transparent texel drawn")
	`SPT_ASSERT(a_miss_clear, clk, arst_n, rsp.valid && !rsp.pixel_write |-> rsp.out_x == '0 && rsp.out_y == '0 && rsp.colour == '0, "miss word not cleared")
	`SPT_ASSERT(a_stall_full, clk, arst_n, !req.ready |-> &vld_q, "input stalled with a free stage")
	`SPT_ASSERT_NEVER(a_store_word_draws, clk, arst_n, rsp.valid && !side_s12.draw && rsp.pixel_write, "store word produced a pixel")
endmodule
`default_nettype wire

/* test/spt_tb_if.sv */
`timescale 1ns / 1ps
// Channels are taken from the RTL interface files (spt_req_if, spt_rsp_if).
// This file only carries the bench-side word types shared by the top module.
package spt_tb_types;
	typedef struct {
		logic               cmd;
		logic [11:0]        texel_index;
		logic [31:0]        texel_value;
		logic [11:0]        pixel_x;
		logic [11:0]        pixel_y;
		logic signed [15:0] sprite_center_x;
		logic [15:0]        spr_width;
		logic [15:0]        spr_height;
		logic signed [31:0] sprite_depth;
		logic [30:0]        column_depth;
	} sprite_word_t;

	typedef struct {
		logic        pixel_write;
		logic [11:0] out_x;
		logic [11:0] out_y;
		logic [31:0] colour;
	} frame_word_t;
endpackage

/* test/sprite_pixel_texture_depth_test_tb.sv */
`timescale 1ns / 1ps
module sprite_pixel_texture_depth_test_tb import spt_pkg::*, spt_tb_types::*; ();

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_wdata;

	spt_req_if req ();
	spt_rsp_if rsp ();

	sprite_pixel_texture_depth_test dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req.sink), .rsp(rsp.source)
	);

	// bench copy of block state
	logic [31:0] texels [0:4095];
	bit          texel_written [0:4095];
	int unsigned scr_w, scr_h, tex_w, tex_h;

	frame_word_t frame_q [$];
	int errors, n_words, n_results, n_writes;
	int src_idle_pct, snk_idle_pct;
	// a new value of hold_seq asks the sink for a long hold-off
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_cnt = 0;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// computes the frame word for a draw; lookup tells whether a store entry is read, entry tells which
	function automatic frame_word_t shade_pixel(sprite_word_t w, output bit lookup,
			output int unsigned entry);
		frame_word_t r;
		longint x, y, cx, sw, sh, dep, wall, tw, th, tx, ty, d, idx;
		r = '{default: '0};
		lookup = 0;
		entry = 0;
		x = w.pixel_x; y = w.pixel_y;
		cx = longint'(w.sprite_center_x);
		sw = w.spr_width; sh = w.spr_height;
		dep = longint'(w.sprite_depth); wall = w.column_depth;
		tw = tex_w; th = tex_h;
		if (sw == 0 || sh == 0) return r;
		if (!(dep > 0 && x > 0 && x < longint'(scr_w) && dep < wall)) return r;
		tx = ((x + sw / 2 - cx) * tw) / sw;
		d = y * 256 - longint'(scr_h) * 128 + sh * 128;
		ty = ((d * th) / sh) / 256;
		if (tx < 0 || tx >= tw || ty < 0 || ty >= th) return r;
		idx = ty * tw + tx;
		if (idx < 0 || idx >= 4096) return r;
		lookup = 1;
		entry = idx;
		if (texels[idx] == 32'd0) return r;
		r.pixel_write = 1'b1;
		r.out_x = 12'(longint'(scr_w) - x - 1);
		r.out_y = w.pixel_y;
		r.colour = texels[idx];
		return r;
	endfunction

	task automatic offer(sprite_word_t w);
		frame_word_t e;
		bit lk;
		int unsigned ent;
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= w.cmd;
		req.texel_index <= w.texel_index;
		req.texel_value <= w.texel_value;
		req.pixel_x <= w.pixel_x;
		req.pixel_y <= w.pixel_y;
		req.sprite_center_x <= w.sprite_center_x;
		req.spr_width <= w.spr_width;
		req.spr_height <= w.spr_height;
		req.sprite_depth <= w.sprite_depth;
		req.column_depth <= w.column_depth;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_words++;
		if (w.cmd == CMD_WRITE) begin
			texels[w.texel_index] = w.texel_value;
			texel_written[w.texel_index] = 1;
			frame_q.push_back('{default: '0});
		end else begin
			e = shade_pixel(w, lk, ent);
			if (e.pixel_write) n_writes++;
			frame_q.push_back(e);
		end
	endtask

	task automatic load_texel(logic [11:0] idx, logic [31:0] val);
		sprite_word_t w;
		w = '{default: '0};
		w.cmd = CMD_WRITE;
		w.texel_index = idx;
		w.texel_value = val;
		offer(w);
	endtask

	// never let a draw read an entry that was never loaded
	task automatic draw(sprite_word_t w);
		bit lk;
		int unsigned ent;
		frame_word_t e;
		w.cmd = CMD_DRAW;
		e = shade_pixel(w, lk, ent);
		if (lk && !texel_written[ent])
			load_texel(12'(ent), ($urandom_range(3) == 0) ? 32'd0 : $urandom);
		offer(w);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (frame_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_reg(cfg_reg_t r, int unsigned v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= 13'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_SCREEN_W: scr_w = v & 13'h1FFF;
			REG_SCREEN_H: scr_h = v & 13'h1FFF;
			REG_TEX_W: tex_w = v & 7'h7F;
			default: tex_h = v & 7'h7F;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(int unsigned sw, int unsigned sh, int unsigned tw,
			int unsigned th);
		drain();
		set_reg(REG_SCREEN_W, sw);
		set_reg(REG_SCREEN_H, sh);
		set_reg(REG_TEX_W, tw);
		set_reg(REG_TEX_H, th);
	endtask

	function automatic sprite_word_t aimed_draw();
		sprite_word_t w;
		int sw, sh, x, y;
		w = '{default: '0};
		w.cmd = CMD_DRAW;
		sw = ($urandom_range(19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 200);
		sh = ($urandom_range(19) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 200);
		x = (scr_w > 1) ? $urandom_range(1, (scr_w > 4096 ? 4095 : scr_w - 1)) : 0;
		y = int'(scr_h / 2) - sh / 2 + int'($urandom_range(0, sh));
		if (y < 0) y = 0;
		if (y > 4095) y = 4095;
		w.spr_width = 16'(sw);
		w.spr_height = 16'(sh);
		w.pixel_x = 12'(x);
		w.pixel_y = 12'(y);
		w.sprite_center_x = 16'(x - sw / 2 + int'($urandom_range(0, sw)));
		w.sprite_depth = $urandom_range(1, 32'h3FFF_FFFF);
		if ($urandom_range(9) == 0)
			w.column_depth = 31'($urandom);
		else
			w.column_depth = 31'(31'(w.sprite_depth) + $urandom_range(1, 1000));
		return w;
	endfunction

	function automatic sprite_word_t noise_word();
		sprite_word_t w;
		w.cmd = 1'($urandom);
		w.texel_index = 12'($urandom);
		w.texel_value = $urandom;
		w.pixel_x = 12'($urandom);
		w.pixel_y = 12'($urandom);
		w.sprite_center_x = 16'($urandom);
		w.spr_width = 16'($urandom);
		w.spr_height = 16'($urandom);
		w.sprite_depth = $urandom;
		w.column_depth = 31'($urandom);
		return w;
	endfunction

	task automatic test_random(int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: load_texel(12'($urandom_range(0, tex_w * tex_h - 1)),
					($urandom_range(4) == 0) ? 32'd0 : $urandom);
				1: draw(noise_word());
				2: load_texel(12'($urandom), $urandom);
				default: draw(aimed_draw());
			endcase
		end
	endtask

	task automatic test_directed();
		sprite_word_t w;
		load_texel(12'd4095, 32'hFFFF_FFFF);
		load_texel(12'd0, 32'd0);
		load_texel(12'd2080, 32'hA5A5_5A5A);
		w = '{default: '0};
		// center pixel of a 64x64 sprite at the screen middle
		w.pixel_x = 12'd320; w.pixel_y = 12'd240; w.sprite_center_x = 16'sd320;
		w.spr_width = 16'd64; w.spr_height = 16'd64;
		w.sprite_depth = 32'sd65536; w.column_depth = 31'd131072;
		draw(w);
		w.column_depth = 31'd65536; draw(w);          // equal depth hidden
		w.column_depth = 31'h7FFF_FFFF; draw(w);
		w.sprite_depth = 32'sd0; draw(w);             // at camera plane
		w.sprite_depth = -32'sd2147483648; draw(w);
		w.sprite_depth = 32'sd2147483647; draw(w);    // level with the far wall
		w.sprite_depth = 32'sd1; draw(w);
		w.spr_width = 16'd0; draw(w);
		w.spr_width = 16'd64; w.spr_height = 16'd0; draw(w);
		w.spr_height = 16'hFFFF; draw(w);
		w.spr_width = 16'hFFFF; draw(w);
		w.spr_width = 16'd64; w.spr_height = 16'd64;
		w.pixel_x = 12'd0; draw(w);                   // left edge excluded
		w.pixel_x = 12'd639; w.sprite_center_x = 16'sd639; draw(w);
		w.pixel_x = 12'd640; draw(w);
		w.pixel_x = 12'hFFF; w.pixel_y = 12'hFFF; draw(w);
		w.pixel_x = 12'd300; w.pixel_y = 12'd240;
		w.sprite_center_x = -16'sd32768; draw(w);     // texel right of texture
		w.sprite_center_x = 16'sd32767; draw(w);
		w.sprite_center_x = 16'sd300; w.pixel_y = 12'd0; draw(w);
		w.pixel_y = 12'd271; draw(w);                 // last row
		w.pixel_y = 12'd272; draw(w);                 // below texture
		w.pixel_x = 12'd280; w.sprite_center_x = 16'sd300; w.pixel_y = 12'd209; draw(w);
		drain();
	endtask

	task automatic test_backpressure();
		int k;
		drain();
		hold_seq++;
		for (k = 0; k < 60; k++) draw(aimed_draw());
		drain();
	endtask

	task automatic test_sender_pause();
		int k;
		for (k = 0; k < 20; k++) draw(aimed_draw());
		drain();
		for (k = 0; k < 20; k++) draw(aimed_draw());
	endtask

	// sink side: random ready with an optional long hold-off
	always @(posedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_cnt <= 300;
			rsp.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("ERROR word %0d: %s got %h want %h", n_results, what, got, want);
	endtask

	always @(posedge clk) begin
		frame_word_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (frame_q.size() == 0)
				report("unexpected word", rsp.pixel_write, 0);
			else begin
				e = frame_q.pop_front();
				if (rsp.pixel_write !== e.pixel_write)
					report("pixel_write", rsp.pixel_write, e.pixel_write);
				if (rsp.out_x !== e.out_x) report("out_x", rsp.out_x, e.out_x);
				if (rsp.out_y !== e.out_y) report("out_y", rsp.out_y, e.out_y);
				if (rsp.colour !== e.colour) report("colour", rsp.colour, e.colour);
			end
			n_results++;
		end
	end

	initial begin
		int ph;
		int cyc;
		errors = 0; n_words = 0; n_results = 0; n_writes = 0;
		src_idle_pct = 32; snk_idle_pct = 46;
		scr_w = 640; scr_h = 480; tex_w = 64; tex_h = 64;
		foreach (texel_written[i]) texel_written[i] = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0; cfg_index <= '0; cfg_wdata <= '0;
		req.valid <= 1'b0; req.cmd <= 1'b0; req.texel_index <= '0; req.texel_value <= '0;
		req.pixel_x <= '0; req.pixel_y <= '0; req.sprite_center_x <= '0;
		req.spr_width <= '0; req.spr_height <= '0; req.sprite_depth <= '0;
		req.column_depth <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(150);
		for (ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 46 : 0;
			snk_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 32 : 0;
			configure(4096, 4096, 64, 64);
			test_random(100);
			configure(1, 1, 1, 1);
			test_random(50);
			configure(320, 200, 16, 8);
			test_random(100);
			configure($urandom_range(2, 4096), $urandom_range(1, 4096),
				$urandom_range(1, 64), $urandom_range(1, 64));
			test_random(100);
			configure(640, 480, 64, 64);
			test_random(80);
		end
		test_backpressure();
		test_sender_pause();
		drain();
		cyc = 0;
		while (frame_q.size() != 0 && cyc < 10000) begin
			@(posedge clk);
			cyc++;
		end
		$display("Covered %0d input words, %0d results, %0d frame writes over several settings",
			n_words, n_results, n_writes);
		$display("including stalls, a long output hold-off and a sender pause");
		if (errors == 0 && frame_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
